### design/wett_pkg.sv
// write era tag table: shared constants, result type and era compare function
// no dependencies
`timescale 1ns / 1ps

package wett_pkg;

  localparam int unsigned ERA_W   = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned LIMIT_W = 7;

  localparam logic [ERA_W-1:0] ERA_MAX = '1;

  // opcodes
  localparam logic [2:0] OP_STAMP   = 3'd0;
  localparam logic [2:0] OP_RESTORE = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_ADVANCE = 3'd3;
  localparam logic [2:0] OP_SCAN    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISMATCH  = 2'd1;
  localparam logic [1:0] ST_AT_MAX    = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // scan compare modes
  localparam logic [1:0] CMP_GT = 2'd0;
  localparam logic [1:0] CMP_GE = 2'd1;
  localparam logic [1:0] CMP_LE = 2'd2;
  localparam logic [1:0] CMP_LT = 2'd3;

  // register byte addresses
  localparam logic [2:0] REG_BLOCKS_IN_USE = 3'd0;

  typedef struct packed {
    logic [1:0]       status;
    logic             matched;
    logic [IDX_W-1:0] match_index;
    logic [ERA_W-1:0] match_era;
    logic [ERA_W-1:0] current_era;
    logic             last;
  } result_t;

  function automatic logic era_test(input logic [ERA_W-1:0] era,
                                    input logic [ERA_W-1:0] test,
                                    input logic [1:0] mode);
    logic hit;
    case (mode)
      CMP_GT:  hit = era > test;
      CMP_GE:  hit = era >= test;
      CMP_LE:  hit = era <= test;
      default: hit = era < test;
    endcase
    return hit;
  endfunction

endpackage

### design/wett_intf.sv
// write era tag table: request and result channel interfaces
// depends on nothing; field widths follow wett_pkg
`timescale 1ns / 1ps

interface wett_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [5:0]  block_index;
  logic [31:0] era_value;
  logic [1:0]  compare_mode;

  modport source(output valid, opcode, block_index, era_value, compare_mode, input ready);
  modport sink(input valid, opcode, block_index, era_value, compare_mode, output ready);
endinterface

interface wett_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        matched;
  logic [5:0]  match_index;
  logic [31:0] match_era;
  logic [31:0] current_era;
  logic        last;

  modport source(output valid, status, matched, match_index, match_era, current_era, last,
                 input ready);
  modport sink(input valid, status, matched, match_index, match_era, current_era, last,
               output ready);
endinterface

### design/wett_apb_regs.sv
// write era tag table: apb register block holding blocks_in_use
// depends on wett_pkg; gives the effective block limit to the core
`timescale 1ns / 1ps

module wett_apb_regs #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [wett_pkg::LIMIT_W-1:0]   limit
);

  localparam logic [wett_pkg::LIMIT_W-1:0] DEPTH_L = wett_pkg::LIMIT_W'(DEPTH);

  logic [wett_pkg::LIMIT_W-1:0] blocks_in_use;
  logic                         sel_blocks;

  assign pready     = 1'b1;
  assign sel_blocks = (paddr[2] == wett_pkg::REG_BLOCKS_IN_USE[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= wett_pkg::LIMIT_W'(64);
    end else if (psel && penable && pwrite && sel_blocks) begin
      blocks_in_use <= pwdata[wett_pkg::LIMIT_W-1:0];
    end
  end

  assign prdata = sel_blocks ? {{(32 - wett_pkg::LIMIT_W){1'b0}}, blocks_in_use} : '0;

  // saturate at what the table actually holds
  assign limit = (blocks_in_use > DEPTH_L) ? DEPTH_L : blocks_in_use;

endmodule

### design/write_era_tag_table_core.sv
// Write era tag table core. Holds one 32-bit write era per cache block in a single-port
// synchronous memory plus a global era counter (reset to 1); per-entry valid flops make every
// entry read as zero after reset, so no clearing pass is needed and items are taken right away.
// Stamp, restore, clear, advance and unused opcodes issue the memory read in the accept cycle;
// the next cycle modifies and writes back and loads the result register, and that
// step repeats while the previous result beat still waits for ready. A scan walks entries
// 0 .. limit-1 one per cycle through the memory read port, pausing while a new match waits
// for a free result register; its steps are accept, limit reads, pipeline drain, final beat.
// limit is blocks_in_use saturated at min(CACHE_BLOCKS, 64). Each scan match leaves as one
// beat with last set on the final one; a scan with no match gives one beat with matched low.
// Depends on wett_pkg, wett_intf and wett_apb_regs.
`timescale 1ns / 1ps

module write_era_tag_table_core #(
  parameter int CACHE_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  wett_req_if.sink    req,
  wett_rsp_if.source  rsp
);

  // only 64 blocks are addressable through the 6-bit index
  localparam int DEPTH = (CACHE_BLOCKS < 64) ? CACHE_BLOCKS : 64;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_EXEC     = 4'b0010,
    S_SCAN     = 4'b0100,
    S_SCAN_END = 4'b1000
  } state_t;

  state_t state;

  logic [wett_pkg::LIMIT_W-1:0] limit;

  // era memory and per-entry valid bits
  logic [wett_pkg::ERA_W-1:0] era_mem [DEPTH];
  logic [DEPTH-1:0]           ent_valid;
  logic [wett_pkg::ERA_W-1:0] rd_era;
  logic                       rd_hit;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [wett_pkg::ERA_W-1:0] wr_data;

  logic [wett_pkg::ERA_W-1:0] cur_era;
  logic [wett_pkg::ERA_W-1:0] cur_era_next;

  // latched request
  logic [2:0]                 op_r;
  logic [wett_pkg::IDX_W-1:0] idx_r;
  logic [wett_pkg::ERA_W-1:0] val_r;
  logic [1:0]                 mode_r;

  // scan walk: read stage counter, evaluate stage, pending match
  logic [wett_pkg::LIMIT_W-1:0] scan_addr;
  logic                         ev_vld;
  logic [AW-1:0]                ev_idx;
  logic                         pend_vld;
  logic [wett_pkg::IDX_W-1:0]   pend_idx;
  logic [wett_pkg::ERA_W-1:0]   pend_era;

  // result register
  wett_pkg::result_t rsp_q;
  logic              rsp_vld;
  logic              rsp_load;

  logic accept;
  logic out_free;
  logic in_range;
  logic exec_go;
  logic [1:0] exec_status;
  logic scan_issue;
  logic scan_go;
  logic [wett_pkg::ERA_W-1:0] ev_era;
  logic ev_match;

  wett_apb_regs #(
    .DEPTH(DEPTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .limit  (limit)
  );

  // one item at a time; a waiting result beat does not block the next accept
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_vld || rsp.ready;

  // ---------------------------------------------------------------------------
  // single-entry operations
  // ---------------------------------------------------------------------------
  assign in_range = {1'b0, idx_r} < limit;
  assign exec_go  = (state == S_EXEC) && out_free;

  always_comb begin
    exec_status  = wett_pkg::ST_OK;
    cur_era_next = cur_era;
    case (op_r) inside
      wett_pkg::OP_STAMP, wett_pkg::OP_CLEAR: begin
        if (!in_range) exec_status = wett_pkg::ST_BAD_INDEX;
      end
      wett_pkg::OP_RESTORE: begin
        if (!in_range) begin
          exec_status = wett_pkg::ST_BAD_INDEX;
        end else if (val_r >= cur_era) begin
          // counter moves past the restored era, sticking at the max
          cur_era_next = (val_r == wett_pkg::ERA_MAX) ? val_r : val_r + 1'b1;
        end
      end
      wett_pkg::OP_ADVANCE: begin
        if (cur_era != val_r) begin
          exec_status = wett_pkg::ST_MISMATCH;
        end else if (cur_era == wett_pkg::ERA_MAX) begin
          exec_status = wett_pkg::ST_AT_MAX;
        end else begin
          cur_era_next = cur_era + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // stamp and restore write the memory, clear only drops the valid bit
  assign wr_en   = exec_go && in_range &&
                   (op_r == wett_pkg::OP_STAMP || op_r == wett_pkg::OP_RESTORE);
  assign wr_addr = idx_r[AW-1:0];
  assign wr_data = (op_r == wett_pkg::OP_STAMP) ? cur_era : val_r;

  // ---------------------------------------------------------------------------
  // scan walk
  // ---------------------------------------------------------------------------
  assign scan_issue = scan_addr < limit;
  assign ev_era     = rd_hit ? rd_era : '0;
  // era zero means unstamped and never matches
  assign ev_match   = ev_vld && (ev_era != '0) && wett_pkg::era_test(ev_era, val_r, mode_r);
  // a new match pushes the held one out, which needs a free result register
  assign scan_go    = (state == S_SCAN) && !(ev_match && pend_vld && !out_free);

  // result register takes a new beat
  assign rsp_load = exec_go || (scan_go && ev_match && pend_vld) ||
                    (state == S_SCAN_END && out_free);

  // read port: request index on accept, walk address during a scan
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = req.block_index[AW-1:0];
    if (state == S_IDLE) begin
      rd_en = accept;
    end else if (state == S_SCAN) begin
      rd_en   = scan_go && scan_issue;
      rd_addr = scan_addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      era_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_era <= era_mem[rd_addr];
      rd_hit <= ent_valid[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_era   <= wett_pkg::ERA_W'(1);
      ent_valid <= '0;
      rsp_vld   <= 1'b0;
      ev_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      scan_addr <= '0;
    end else begin
      rsp_vld <= rsp_load || (rsp_vld && !rsp.ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state     <= (req.opcode == wett_pkg::OP_SCAN) ? S_SCAN : S_EXEC;
            scan_addr <= '0;
            ev_vld    <= 1'b0;
            pend_vld  <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            cur_era <= cur_era_next;
            state   <= S_IDLE;
            if (in_range && (op_r == wett_pkg::OP_STAMP || op_r == wett_pkg::OP_RESTORE))
              ent_valid[wr_addr] <= 1'b1;
            if (in_range && op_r == wett_pkg::OP_CLEAR)
              ent_valid[wr_addr] <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            ev_vld <= scan_issue;
            if (scan_issue) scan_addr <= scan_addr + 1'b1;
            if (ev_match) begin
              ent_valid[ev_idx] <= 1'b0;
              pend_vld          <= 1'b1;
            end
            // the last entry is evaluated on the cycle no new read goes out
            if (!scan_issue) state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          if (out_free) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req.opcode;
      idx_r  <= req.block_index;
      val_r  <= req.era_value;
      mode_r <= req.compare_mode;
    end
    if (exec_go) begin
      rsp_q <= '{status: exec_status, matched: 1'b0, match_index: '0, match_era: '0,
                 current_era: cur_era_next, last: 1'b1};
    end
    if (scan_go) begin
      if (scan_issue) ev_idx <= scan_addr[AW-1:0];
      if (ev_match) begin
        pend_idx <= wett_pkg::IDX_W'(ev_idx);
        pend_era <= ev_era;
        // the held match is not the final one
        if (pend_vld) begin
          rsp_q <= '{status: wett_pkg::ST_OK, matched: 1'b1, match_index: pend_idx,
                     match_era: pend_era, current_era: cur_era, last: 1'b0};
        end
      end
    end
    if (state == S_SCAN_END && out_free) begin
      rsp_q <= '{status: wett_pkg::ST_OK, matched: pend_vld,
                 match_index: pend_vld ? pend_idx : '0,
                 match_era: pend_vld ? pend_era : '0,
                 current_era: cur_era, last: 1'b1};
    end
  end

  assign rsp.valid       = rsp_vld;
  assign rsp.status      = rsp_q.status;
  assign rsp.matched     = rsp_q.matched;
  assign rsp.match_index = rsp_q.match_index;
  assign rsp.match_era   = rsp_q.match_era;
  assign rsp.current_era = rsp_q.current_era;
  assign rsp.last        = rsp_q.last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // counter starts at one and only grows or saturates
  a_counter_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_era != '0)
    else $error("era counter reached zero");

  // the walk never evaluates an entry beyond the block limit
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    ev_vld |-> (wett_pkg::LIMIT_W'(ev_idx) < limit))
    else $error("scan evaluated an entry beyond the limit");

  // a held match only lives inside a scan
  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> (state == S_SCAN || state == S_SCAN_END))
    else $error("pending match outside a scan");

  // a finished single-entry operation leaves exactly one final beat
  a_exec_beat: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (rsp_vld && rsp_q.last && !rsp_q.matched && state == S_IDLE))
    else $error("single-entry operation did not produce its result beat");

endmodule

### dv/wett_era_checker.sv
// write era tag table: checker that watches the request, result and register ports,
// predicts every result beat and compares it field by field
// depends on wett_pkg and wett_intf
`timescale 1ns / 1ps

module wett_era_checker
  import wett_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wett_req_if         req,
  wett_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding,
  output int          beats_checked,
  output logic [31:0] era_now
);

  localparam int unsigned TABLE_DEPTH = 64;

  logic [ERA_W-1:0]   era_of_block [TABLE_DEPTH];
  logic [ERA_W-1:0]   era_count;
  logic [LIMIT_W-1:0] blocks_cfg;
  result_t            results_due [$];
  int                 mism_n;
  int                 checked_n;

  function automatic string show(input result_t r);
    return $sformatf("st=%0d m=%0d idx=%0d era=%0h cur=%0h last=%0d", r.status, r.matched,
                     r.match_index, r.match_era, r.current_era, r.last);
  endfunction

  // apply one request to the shadow table and queue the beats it produces
  task automatic predict_beats(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                               input logic [ERA_W-1:0] val, input logic [1:0] mode);
    int unsigned lim;
    result_t     r;
    logic        hit;
    bit          any;
    lim = (blocks_cfg > TABLE_DEPTH) ? TABLE_DEPTH : blocks_cfg;
    r = '0;
    any = 1'b0;
    if (op == OP_SCAN) begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (era_of_block[i] != '0) begin
          case (mode)
            CMP_GT:  hit = era_of_block[i] > val;
            CMP_GE:  hit = era_of_block[i] >= val;
            CMP_LE:  hit = era_of_block[i] <= val;
            default: hit = era_of_block[i] < val;
          endcase
          if (hit) begin
            r = '0;
            r.matched     = 1'b1;
            r.match_index = IDX_W'(i);
            r.match_era   = era_of_block[i];
            r.current_era = era_count;
            results_due.push_back(r);
            era_of_block[i] = '0;
            any = 1'b1;
          end
        end
      end
      if (any) begin
        r = results_due.pop_back();
        r.last = 1'b1;
        results_due.push_back(r);
      end else begin
        r = '0;
        r.current_era = era_count;
        r.last = 1'b1;
        results_due.push_back(r);
      end
    end else begin
      r.status = ST_OK;
      if (op <= OP_CLEAR && idx >= lim) begin
        r.status = ST_BAD_INDEX;
      end else begin
        case (op)
          OP_STAMP:   era_of_block[idx] = era_count;
          OP_RESTORE: begin
            era_of_block[idx] = val;
            if (val >= era_count) era_count = (val == ERA_MAX) ? val : val + 1'b1;
          end
          OP_CLEAR:   era_of_block[idx] = '0;
          OP_ADVANCE: begin
            if (era_count != val) r.status = ST_MISMATCH;
            else if (era_count == ERA_MAX) r.status = ST_AT_MAX;
            else era_count = era_count + 1'b1;
          end
          default: ;
        endcase
      end
      r.current_era = era_count;
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      foreach (era_of_block[i]) era_of_block[i] = '0;
      era_count  = 1;
      blocks_cfg = 7'd64;
      results_due.delete();
      mism_n    = 0;
      checked_n = 0;
    end else begin
      // result side first: a beat can never belong to a request taken at this edge
      if (rsp.valid && rsp.ready) begin
        got.status      = rsp.status;
        got.matched     = rsp.matched;
        got.match_index = rsp.match_index;
        got.match_era   = rsp.match_era;
        got.current_era = rsp.current_era;
        got.last        = rsp.last;
        checked_n++;
        if (results_due.size() == 0) begin
          mism_n++;
          if (mism_n <= 10) $display("%t unexpected result beat: %s", $realtime, show(got));
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.matched !== want.matched ||
              got.match_index !== want.match_index || got.match_era !== want.match_era ||
              got.current_era !== want.current_era || got.last !== want.last) begin
            mism_n++;
            if (mism_n <= 10)
              $display("%t result mismatch\n  expected %s\n  actual   %s", $realtime,
                       show(want), show(got));
          end
        end
      end
      if (req.valid && req.ready)
        predict_beats(req.opcode, req.block_index, req.era_value, req.compare_mode);
      if (psel && penable && pready && paddr == REG_BLOCKS_IN_USE) begin
        if (pwrite) begin
          blocks_cfg = pwdata[LIMIT_W-1:0];
        end else if (prdata[LIMIT_W-1:0] !== blocks_cfg) begin
          mism_n++;
          if (mism_n <= 10)
            $display("%t blocks_in_use readback: expected %0d actual %0d", $realtime,
                     blocks_cfg, prdata[LIMIT_W-1:0]);
        end
      end
    end
    errors        <= mism_n;
    beats_checked <= checked_n;
    outstanding   <= results_due.size();
    era_now       <= era_count;
  end

endmodule

### dv/tb_top.sv
// write era tag table: testbench top, drives requests, register writes and result backpressure
// depends on wett_pkg, wett_intf, write_era_tag_table_core and wett_era_checker
`timescale 1ns / 1ps

module tb_top;
  import wett_pkg::*;

  // one request beat as the sender sees it
  typedef struct packed {
    logic [2:0]       opcode;
    logic [IDX_W-1:0] block_index;
    logic [ERA_W-1:0] era_value;
    logic [1:0]       compare_mode;
  } era_req_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wett_req_if req_ch ();
  wett_rsp_if rsp_ch ();

  int          errors;
  int          outstanding;
  int          beats_checked;
  logic [31:0] era_now;

  // no random idling on either side while set
  bit          calm;
  int          n_sent;
  int          n_scans;
  int          n_settings;

  write_era_tag_table_core DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  wett_era_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors        (errors),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .era_now       (era_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure: ready drops about 15% of cycles unless calm
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout: run did not finish in time");
    $display("Test completed with failures");
    $finish;
  end

  // all tasks below are entered just after a rising edge and leave just after one

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register read, the checker compares prdata on the access beat
  task automatic reg_read(input logic [2:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // present one beat and hold it until the block takes it, then maybe idle
  task automatic send_req(input era_req_t r);
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= r.opcode;
    req_ch.block_index  <= r.block_index;
    req_ch.era_value    <= r.era_value;
    req_ch.compare_mode <= r.compare_mode;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
    if (r.opcode == OP_SCAN) n_scans++;
    if (!calm && $urandom_range(0, 99) < 15) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic put(input logic [2:0] op, input int unsigned idx,
                     input logic [31:0] val, input logic [1:0] mode);
    era_req_t r;
    r.opcode       = op;
    r.block_index  = IDX_W'(idx);
    r.era_value    = val;
    r.compare_mode = mode;
    send_req(r);
  endtask

  // stop sending until every predicted beat has come back; the extra edge lets
  // the checker count the beat accepted at the edge we came in on
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_blocks(input logic [31:0] data);
    reg_write(REG_BLOCKS_IN_USE, data);
    reg_read(REG_BLOCKS_IN_USE);
    n_settings++;
  endtask

  // mostly well-formed traffic: indices inside the block count, restores and scan
  // eras near the live counter; wild widens eras to the full 32-bit range
  function automatic era_req_t rand_req(input int unsigned lim, input logic [31:0] cur,
                                        input bit wild);
    era_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.compare_mode = 2'($urandom_range(0, 3));
    r.era_value    = $urandom();
    if (lim != 0 && $urandom_range(0, 99) < 85) r.block_index = IDX_W'($urandom_range(0, lim - 1));
    else r.block_index = IDX_W'($urandom_range(0, 63));
    if (pick < 25) begin
      r.opcode = OP_STAMP;
    end else if (pick < 45) begin
      r.opcode = OP_RESTORE;
      if (!wild) r.era_value = ((cur > 3) ? cur - 3 : 32'd0) + $urandom_range(0, 8);
    end else if (pick < 55) begin
      r.opcode = OP_CLEAR;
    end else if (pick < 72) begin
      r.opcode = OP_ADVANCE;
      if ($urandom_range(0, 3) == 0) r.era_value = cur + 1'b1;
    end else if (pick < 92) begin
      r.opcode = OP_SCAN;
      if (!wild) r.era_value = $urandom_range(0, cur + 1);
    end else begin
      // unused opcodes, the block must answer with a plain ok beat
      r.opcode = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  task automatic run_random(input int n, input int unsigned lim, input bit wild);
    era_req_t r;
    for (int k = 0; k < n; k++) begin
      r = rand_req(lim, era_now, wild);
      // most advances carry the right counter, read from era_now after the request line goes idle
      if (r.opcode == OP_ADVANCE && $urandom_range(0, 4) != 0) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        r.era_value = era_now;
      end
      send_req(r);
      if ($urandom_range(0, 99) < 2) wait_drained();
    end
  endtask

  initial begin
    int unsigned blk_settings [7];
    int unsigned eff;
    int unsigned guard;
    blk_settings = '{1, 0, 127, 37, 2, 100, 64};
    n_sent     = 0;
    n_scans    = 0;
    n_settings = 0;
    calm       = 1'b0;

    // every block input known from time zero
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= '0;
    req_ch.block_index  <= '0;
    req_ch.era_value    <= '0;
    req_ch.compare_mode <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full table, counter starts at 1
    set_blocks(32'd64);

    // advance: mismatch, then two good ones, counter goes to 3
    put(OP_ADVANCE, 0, 32'hFFFF_FFFF, CMP_GT);
    put(OP_ADVANCE, 0, 32'd1, CMP_GE);
    put(OP_ADVANCE, 0, 32'd2, CMP_LE);
    // stamps at both ends of the table
    put(OP_STAMP, 0, 32'd0, CMP_LT);
    put(OP_STAMP, 63, 32'hFFFF_FFFF, CMP_GT);
    put(OP_STAMP, 17, 32'd0, CMP_GT);
    // restore above the counter lifts it to 101, restore below leaves it
    put(OP_RESTORE, 5, 32'd100, CMP_GT);
    put(OP_RESTORE, 6, 32'd50, CMP_GT);
    put(OP_ADVANCE, 0, 32'd101, CMP_GT);
    put(OP_STAMP, 7, 32'd0, CMP_GT);
    put(OP_CLEAR, 17, 32'd0, CMP_GT);
    // unused opcodes
    put(3'd5, 63, 32'hFFFF_FFFF, CMP_LT);
    put(3'd6, 0, 32'd0, CMP_GT);
    put(3'd7, 42, 32'h5555_AAAA, CMP_GE);
    // one scan per compare mode, each hit is cleared so later scans see less
    put(OP_SCAN, 0, 32'd100, CMP_GT);
    put(OP_SCAN, 0, 32'd50, CMP_GE);
    put(OP_SCAN, 0, 32'd3, CMP_LE);
    put(OP_SCAN, 0, 32'd1000, CMP_LT);
    // nothing stamped any more: a single no-match beat
    put(OP_SCAN, 0, 32'd0, CMP_GT);

    // stretch with no idling on either side
    calm = 1'b1;
    run_random(10, 64, 1'b0);
    wait_drained();
    run_random(10, 64, 1'b0);
    calm = 1'b0;

    // walk the block count through its extremes and a few odd values
    foreach (blk_settings[s]) begin
      wait_drained();
      eff = (blk_settings[s] > 64) ? 64 : blk_settings[s];
      if (blk_settings[s] == 100)
        set_blocks({25'($urandom()), 7'(blk_settings[s])});
      else
        set_blocks(32'(blk_settings[s]));
      if (blk_settings[s] == 1) begin
        // indices past the single block in use are rejected
        put(OP_STAMP, 1, 32'd0, CMP_GT);
        put(OP_RESTORE, 63, 32'd5, CMP_GT);
        put(OP_CLEAR, 1, 32'd0, CMP_GT);
        put(OP_STAMP, 0, 32'd0, CMP_GT);
        put(OP_SCAN, 0, 32'd0, CMP_GE);
      end else if (blk_settings[s] == 0) begin
        // no block in use at all
        put(OP_STAMP, 0, 32'd0, CMP_GT);
        put(OP_SCAN, 0, 32'd0, CMP_GT);
      end
      run_random(15, eff, 1'b0);
    end

    // counter saturation, block count back at 64
    wait_drained();
    put(OP_RESTORE, 9, ERA_MAX - 1'b1, CMP_GT);
    put(OP_ADVANCE, 0, ERA_MAX, CMP_GT);
    put(OP_ADVANCE, 0, 32'd0, CMP_GT);
    put(OP_STAMP, 11, 32'd0, CMP_GT);
    put(OP_RESTORE, 12, ERA_MAX, CMP_GT);
    put(OP_RESTORE, 13, 32'd0, CMP_GT);
    put(OP_SCAN, 0, ERA_MAX, CMP_GE);
    put(OP_SCAN, 0, 32'd0, CMP_LT);
    put(OP_SCAN, 0, ERA_MAX, CMP_LE);
    run_random(20, 64, 1'b1);

    // drain, then keep the clock running for stray beats before the summary
    req_ch.valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (outstanding != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (outstanding != 0) begin
      $display("timeout: %0d result beats still missing", outstanding);
      $display("Test completed with failures");
      $finish;
    end else begin
      repeat (80) @(posedge clk);
      $display("covered %0d request beats (%0d scans) over %0d block-count settings",
               n_sent, n_scans, n_settings);
      $display("%0d result beats compared, %0d failures", beats_checked, errors);
      if (errors == 0 && outstanding == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
      $finish;
    end
  end

endmodule
